/* hw/rtl/hysteresis_trigger_gate_macros.svh */
// Assertion macros shared by the hysteresis trigger gate RTL.
`ifndef HYSTERESIS_TRIGGER_GATE_MACROS_SVH
`define HYSTERESIS_TRIGGER_GATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/htg_pkg.sv */
// Shared types, register map and constants of the hysteresis trigger gate.
`default_nettype none
package htg_pkg;

  localparam int NUM_CLASSES_DEF = 32;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;
  localparam int CLS_W           = 5;
  localparam int SCORE_W         = 16;
  localparam int TIME_W          = 32;
  localparam int DUR_W           = 16;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [SCORE_W-1:0] HIGH_THR_RST = 16'd52429;
  localparam logic [SCORE_W-1:0] LOW_THR_RST  = 16'd19661;

  typedef enum logic [2:0] {
    REG_HIGH_THR    = 3'd0,
    REG_LOW_THR     = 3'd1,
    REG_HIGH_DWELL  = 3'd2,
    REG_LOW_DWELL   = 3'd3,
    REG_COOLDOWN    = 3'd4,
    REG_REPEAT_MODE = 3'd5,
    REG_REPEAT_INT  = 3'd6,
    REG_CLASS_MASK  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SCORE_W-1:0] high_threshold;
    logic [SCORE_W-1:0] low_threshold;
    logic [DUR_W-1:0]   high_dwell_ms;
    logic [DUR_W-1:0]   low_dwell_ms;
    logic [DUR_W-1:0]   refire_gap_ms;
    logic               repeat_mode;
    logic [DUR_W-1:0]   repeat_interval_ms;
    logic [31:0]        class_enable_mask;
  } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/hysteresis_trigger_gate.sv */
// Top level of the hysteresis trigger gate: per-class Schmitt gates with dwell and cooldown.
//
// Usage:
//   Input stream (s_*): one beat per command. s_tuser is the function (0 score
//   sample, 1 clear all gates). s_tdata carries class, score and time stamp.
//   Output stream (m_*): one beat per score sample of an enabled, in-range
//   class; clear beats and samples of disabled classes produce no beat.
//   Configuration: APB port, register i at byte address 4*i, write only while idle.
// Path: a beat accepted into the input register is decided from there into the output
//   register, which drives m_tvalid.
// Throughput: one beat per cycle while m_tready does not stall the output; the per-class
//   state sits in flip-flops and is read and written by a single compare-and-subtract
//   pass between the input register and the output register.
// Reset: all gates idle, no holds, no fire history; registers take reset values.
// Stall: while m_tready is low the output register holds its beat and the
//   input register keeps one more; s_tready drops once both are full.
`default_nettype none
`include "hysteresis_trigger_gate_macros.svh"
module hysteresis_trigger_gate #(
  parameter int NUM_CLASSES = htg_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_tdata: class_index[4:0], score[20:5], now_ms[52:21], zero pad
  input  wire logic [htg_pkg::IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: func[0]
  input  wire logic                            s_tuser,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // m_tdata: event_class[4:0], event_score[20:5], fired[21], armed[22], holding[23]
  output logic      [htg_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [htg_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [htg_pkg::DATA_W-1:0]      pwdata,
  output logic      [htg_pkg::DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import htg_pkg::*;

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  cfg_t cfg;

  htg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic               in_valid;
  logic               q_func;
  logic [CLS_W-1:0]   q_cls;
  logic [SCORE_W-1:0] q_score;
  logic [TIME_W-1:0]  q_now;

  // per-class state
  logic [NUM_CLASSES-1:0] gate_armed;
  logic [NUM_CLASSES-1:0] hold_running;
  logic [NUM_CLASSES-1:0] has_fired;
  logic [TIME_W-1:0]      hold_start_ms [NUM_CLASSES];
  logic [TIME_W-1:0]      last_fire_ms  [NUM_CLASSES];

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              live;
  logic              out_free;
  logic              advance;
  logic              armed_c;
  logic              hold_c;
  logic              hf_c;
  logic              hi;
  logic              lo;
  logic [DUR_W-1:0]  dwell;
  logic [TIME_W-1:0] hold_el;
  logic [TIME_W-1:0] fire_el;
  logic              hold_done;
  logic              cool_ok;
  logic              rep_ok;
  logic              armed_next;
  logic              hold_next;
  logic              set_start;
  logic              fire;

  assign idx      = IDX_W'(q_cls);
  assign in_range = (32'(q_cls) < NUM_CLASSES);
  assign live     = !q_func && in_range && cfg.class_enable_mask[q_cls];
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!live || out_free);
  assign s_tready = !in_valid || advance;

  assign armed_c = gate_armed[idx];
  assign hold_c  = hold_running[idx];
  assign hf_c    = has_fired[idx];
  assign hi      = (q_score >= cfg.high_threshold);
  assign lo      = (q_score <= cfg.low_threshold);
  assign dwell   = armed_c ? cfg.low_dwell_ms : cfg.high_dwell_ms;
  assign hold_el = q_now - hold_start_ms[idx];
  assign fire_el = q_now - last_fire_ms[idx];

  assign hold_done = (hold_el >= TIME_W'(dwell));
  assign cool_ok   = (cfg.refire_gap_ms == '0) || !hf_c ||
                     (fire_el >= TIME_W'(cfg.refire_gap_ms));
  assign rep_ok    = cfg.repeat_mode && (cfg.repeat_interval_ms != '0) && hf_c &&
                     (fire_el >= TIME_W'(cfg.repeat_interval_ms));

  always_comb begin
    armed_next = armed_c;
    hold_next  = hold_c;
    set_start  = 1'b0;
    fire       = 1'b0;
    if (!armed_c) begin
      if (hi) begin
        if (!hold_c) begin
          hold_next = 1'b1;
          set_start = 1'b1;
        end else if (hold_done) begin
          fire       = cool_ok;
          armed_next = 1'b1;
          hold_next  = 1'b0;
        end
      end else begin
        hold_next = 1'b0;
      end
    end else begin
      if (hi) begin
        hold_next = 1'b0;
        fire      = rep_ok;
      end else if (lo) begin
        if (!hold_c) begin
          hold_next = 1'b1;
          set_start = 1'b1;
        end else if (hold_done) begin
          armed_next = 1'b0;
          hold_next  = 1'b0;
        end
      end else begin
        hold_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_func  <= s_tuser;
      q_cls   <= s_tdata[4:0];
      q_score <= s_tdata[20:5];
      q_now   <= s_tdata[52:21];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_armed   <= '0;
      hold_running <= '0;
      has_fired    <= '0;
    end else if (advance && q_func) begin
      gate_armed   <= '0;
      hold_running <= '0;
    end else if (advance && live) begin
      gate_armed[idx]   <= armed_next;
      hold_running[idx] <= hold_next;
      if (fire) begin
        has_fired[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && live && set_start) begin
      hold_start_ms[idx] <= q_now;
    end
    if (advance && live && fire) begin
      last_fire_ms[idx] <= q_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && live) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && live) begin
      m_tdata <= {hold_next, armed_next, fire, q_score, q_cls};
    end
  end

  `HTG_ASSERT_NOW(a_fire_armed, m_tvalid, !m_tdata[21] || m_tdata[22], "fire without armed gate")
  `HTG_ASSERT_NEXT(a_clear_all, advance && q_func, (gate_armed == '0) && (hold_running == '0), "clear left gate state")
  `HTG_ASSERT_NEXT(a_keep_item, in_valid && !advance, in_valid, "pending beat lost")
  `HTG_ASSERT_NEXT(a_state_hold, !advance, $stable(gate_armed) && $stable(hold_running), "gate state moved without beat")

endmodule
`default_nettype wire

/* hw/rtl/htg_regs.sv */
// APB configuration register file of the hysteresis trigger gate.
`default_nettype none
module htg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [htg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [htg_pkg::DATA_W-1:0] pwdata,
  output logic      [htg_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output htg_pkg::cfg_t                   cfg
);
  import htg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold     <= HIGH_THR_RST;
      cfg.low_threshold      <= LOW_THR_RST;
      cfg.high_dwell_ms      <= '0;
      cfg.low_dwell_ms       <= '0;
      cfg.refire_gap_ms      <= '0;
      cfg.repeat_mode        <= 1'b0;
      cfg.repeat_interval_ms <= '0;
      cfg.class_enable_mask  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_HIGH_THR:    cfg.high_threshold     <= pwdata[SCORE_W-1:0];
        REG_LOW_THR:     cfg.low_threshold      <= pwdata[SCORE_W-1:0];
        REG_HIGH_DWELL:  cfg.high_dwell_ms      <= pwdata[DUR_W-1:0];
        REG_LOW_DWELL:   cfg.low_dwell_ms       <= pwdata[DUR_W-1:0];
        REG_COOLDOWN:    cfg.refire_gap_ms      <= pwdata[DUR_W-1:0];
        REG_REPEAT_MODE: cfg.repeat_mode        <= pwdata[0];
        REG_REPEAT_INT:  cfg.repeat_interval_ms <= pwdata[DUR_W-1:0];
        REG_CLASS_MASK:  cfg.class_enable_mask  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_HIGH_THR:    prdata = DATA_W'(cfg.high_threshold);
      REG_LOW_THR:     prdata = DATA_W'(cfg.low_threshold);
      REG_HIGH_DWELL:  prdata = DATA_W'(cfg.high_dwell_ms);
      REG_LOW_DWELL:   prdata = DATA_W'(cfg.low_dwell_ms);
      REG_COOLDOWN:    prdata = DATA_W'(cfg.refire_gap_ms);
      REG_REPEAT_MODE: prdata = DATA_W'(cfg.repeat_mode);
      REG_REPEAT_INT:  prdata = DATA_W'(cfg.repeat_interval_ms);
      REG_CLASS_MASK:  prdata = DATA_W'(cfg.class_enable_mask);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
